FILE: hdl/gbc_pkg.sv
// Shared constants and types for the gyroscope bias calibration core.
package gbc_pkg;

  localparam int SAMPLE_COUNT = 256;
  localparam int SAMPLE_W     = 16;
  localparam int RATE_W       = 21;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CNT_W        = 16;
  localparam int LIMIT_W      = 15;
  localparam int MEAN_SHIFT   = $clog2(SAMPLE_COUNT);
  localparam int SUM_W        = SAMPLE_W + MEAN_SHIFT;
  localparam int THR_W        = SAMPLE_W + $clog2(SAMPLE_COUNT + 1);
  localparam int PROD_W       = 23;
  localparam int RATE_MUL     = 35;

  localparam logic [CFG_IDX_W-1:0] REG_DISCARD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS    = 2'd2;

  typedef struct packed {
    logic clr;
    logic acc;
    logic load;
  } lane_ctl_t;

  typedef struct packed {
    logic spread_bad;
    logic mean_bad;
  } lane_sts_t;

endpackage

FILE: hdl/gbc_lane.sv
// One axis lane: rate correction, run statistics and the bias update.
module gbc_lane import gbc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  lane_ctl_t                  ctl,
  input  logic        [CFG_W-1:0]    spread_limit,
  input  logic        [LIMIT_W-1:0]  bias_limit,
  output logic signed [RATE_W-1:0]   rate,
  output lane_sts_t                  sts
);

  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic signed [SAMPLE_W-1:0] bias_r;

  logic signed [SUM_W-1:0]    sum_nxt;
  logic signed [SAMPLE_W-1:0] min_nxt;
  logic signed [SAMPLE_W-1:0] max_nxt;
  logic        [SUM_W-1:0]    mag_new;
  logic        [SAMPLE_W-1:0] mean_mag;
  logic        [THR_W-1:0]    mean_thr;
  logic signed [SAMPLE_W:0]   spread;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   adj;

  // Correction: (sample - bias) * 35 / 4, rounded toward zero.
  always_comb begin
    diff = {sample[SAMPLE_W-1], sample} - {bias_r[SAMPLE_W-1], bias_r};
    prod = PROD_W'(diff) * PROD_W'(RATE_MUL);
    adj  = prod + (prod[PROD_W-1] ? PROD_W'(3) : PROD_W'(0));
    rate = adj[PROD_W-1:2];
  end

  // Statistics including the current sample, used for the end-of-run checks.
  always_comb begin
    sum_nxt  = sum_r + SUM_W'(sample);
    min_nxt  = (sample < min_r) ? sample : min_r;
    max_nxt  = (sample > max_r) ? sample : max_r;
    mag_new  = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);
    mean_mag = SAMPLE_W'(mag_new >> MEAN_SHIFT);
    mean_thr = THR_W'({1'b0, bias_limit} + 16'd1) * THR_W'(SAMPLE_COUNT);
    spread   = {max_nxt[SAMPLE_W-1], max_nxt} - {min_nxt[SAMPLE_W-1], min_nxt};
    sts.spread_bad = spread > $signed({1'b0, spread_limit});
    sts.mean_bad   = THR_W'(mag_new) >= mean_thr;
  end

  // The mean is the magnitude shifted down by log2 of the sample count, sign restored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else if (ctl.load) begin
      bias_r <= sum_nxt[SUM_W-1] ? -$signed(mean_mag) : $signed(mean_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      sum_r <= '0;
      min_r <= {1'b0, {(SAMPLE_W-1){1'b1}}};
      max_r <= {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else if (ctl.acc) begin
      sum_r <= sum_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

endmodule

FILE: hdl/gyro_bias_calibrate_and_correct_core.sv
// Top level: run control, merge of the three axis lanes and result register.
//
// Usage. An input beat is taken on a rising edge with start high and busy low.
// in_kind 0 carries a three-axis rate sample, in_kind 1 starts a calibration
// run (sample fields ignored). Every beat produces exactly one result beat in the
// next cycle, marked by out_valid for a single cycle; the receiver cannot
// stall, so results are never held back.
// A run skips discard_count samples, then accumulates SAMPLE_COUNT samples per
// axis. The beat that ends the run reports cal_done and cal_ok; on an accepted
// run each lane loads its new bias at that same edge, so it applies from the
// next beat. Busy is always low and one beat per cycle is accepted.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect at
// once; writes to an unused index are ignored.
// Synchronous reset restores the register defaults (64, 100, 1000), clears
// the bias and its valid mark and returns the run control to idle.
module gyro_bias_calibrate_and_correct_core import gbc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_kind,
  input  logic signed [SAMPLE_W-1:0] in_x_sample,
  input  logic signed [SAMPLE_W-1:0] in_y_sample,
  input  logic signed [SAMPLE_W-1:0] in_z_sample,
  output logic                       out_valid,
  output logic signed [RATE_W-1:0]   out_x_rate,
  output logic signed [RATE_W-1:0]   out_y_rate,
  output logic signed [RATE_W-1:0]   out_z_rate,
  output logic                       out_calibrating,
  output logic                       out_cal_done,
  output logic                       out_cal_ok,
  output logic                       out_bias_ok,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  typedef enum logic [1:0] {PH_IDLE, PH_DISCARD, PH_ACCUM} phase_t;

  phase_t              phase_r, phase_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                valid_r, valid_nxt;
  logic [CFG_W-1:0]    discard_r;
  logic [CFG_W-1:0]    spread_r;
  logic [LIMIT_W-1:0]  limit_r;

  logic                accept;
  logic                final_beat;
  logic                run_ok;
  logic [CNT_W-1:0]    acc_cnt;
  lane_ctl_t           ctl;
  lane_sts_t           sts_x, sts_y, sts_z;
  logic signed [RATE_W-1:0] rate_x, rate_y, rate_z;

  logic                      out_valid_r;
  logic signed [RATE_W-1:0]  out_x_r, out_y_r, out_z_r;
  logic                      out_cal_r, out_done_r, out_ok_r, out_bias_ok_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  gbc_lane u_lane_x (
    .clk(clk), .rst_n(rst_n), .sample(in_x_sample), .ctl(ctl),
    .spread_limit(spread_r), .bias_limit(limit_r), .rate(rate_x), .sts(sts_x)
  );
  gbc_lane u_lane_y (
    .clk(clk), .rst_n(rst_n), .sample(in_y_sample), .ctl(ctl),
    .spread_limit(spread_r), .bias_limit(limit_r), .rate(rate_y), .sts(sts_y)
  );
  gbc_lane u_lane_z (
    .clk(clk), .rst_n(rst_n), .sample(in_z_sample), .ctl(ctl),
    .spread_limit(spread_r), .bias_limit(limit_r), .rate(rate_z), .sts(sts_z)
  );

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    valid_nxt   = valid_r;
    final_beat  = 1'b0;
    acc_cnt     = '0;
    ctl         = '0;
    run_ok      = !(sts_x.spread_bad || sts_x.mean_bad || sts_y.spread_bad ||
                    sts_y.mean_bad || sts_z.spread_bad || sts_z.mean_bad);
    if (accept) begin
      if (in_kind) begin
        phase_nxt = PH_DISCARD;
        cnt_nxt   = '0;
        valid_nxt = 1'b0;
        ctl.clr   = 1'b1;
      end else begin
        if (phase_r == PH_DISCARD) begin
          if (cnt_r >= discard_r) begin
            phase_nxt = PH_ACCUM;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (phase_nxt == PH_ACCUM) begin
          ctl.acc = 1'b1;
          acc_cnt = cnt_nxt + 1'b1;
          cnt_nxt = acc_cnt;
          if (acc_cnt >= CNT_W'(SAMPLE_COUNT)) begin
            final_beat = 1'b1;
            phase_nxt  = PH_IDLE;
            cnt_nxt    = '0;
            if (run_ok) begin
              valid_nxt = 1'b1;
              ctl.load  = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      cnt_r         <= '0;
      valid_r       <= 1'b0;
      discard_r     <= CFG_W'(64);
      spread_r      <= CFG_W'(100);
      limit_r       <= LIMIT_W'(1000);
      out_valid_r   <= 1'b0;
      out_cal_r     <= 1'b0;
      out_done_r    <= 1'b0;
      out_ok_r      <= 1'b0;
      out_bias_ok_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= accept;
      if (accept) begin
        out_cal_r     <= phase_nxt != PH_IDLE;
        out_done_r    <= final_beat;
        out_ok_r      <= final_beat && run_ok;
        out_bias_ok_r <= valid_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DISCARD: discard_r <= cfg_data;
          REG_SPREAD:  spread_r  <= cfg_data;
          REG_BIAS:    limit_r   <= cfg_data[LIMIT_W-1:0];
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_x_r <= in_kind ? '0 : rate_x;
      out_y_r <= in_kind ? '0 : rate_y;
      out_z_r <= in_kind ? '0 : rate_z;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x_rate      = out_x_r;
  assign out_y_rate      = out_y_r;
  assign out_z_rate      = out_z_r;
  assign out_calibrating = out_cal_r;
  assign out_cal_done    = out_done_r;
  assign out_cal_ok      = out_ok_r;
  assign out_bias_ok     = out_bias_ok_r;

endmodule
